@@ hw/rtl/vtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared widths, defaults, status codes, result types and the saturating
// 64-bit add used by the matrix sums.
// ----------------------------------------------------------------------------
package vtpd_pkg;

   // Fixed widths of the ports.
   localparam int COORD_W   = 32;
   localparam int MAT_W     = 64;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = 3;

   // Default fixed-point format.
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COORD_BITS_DEF = 32;

   // Status codes returned with each result word.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_WZERO = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   // Result of one divider lane.
   typedef struct packed {
      logic               sat;
      logic [COORD_W-1:0] val;
   } div_res_type;

   // Sum with overflow indication.
   typedef struct packed {
      logic               ovf;
      logic [MAT_W-1:0]   sum;
   } sat_sum_type;

   // Signed 64-bit add that clamps to the int64 range on overflow.
   function automatic sat_sum_type sat_add(input logic [MAT_W-1:0] a,
                                           input logic [MAT_W-1:0] b);
      sat_sum_type      res;
      logic [MAT_W-1:0] raw;
      raw     = a + b;
      res.ovf = 1'b0;
      res.sum = raw;
      if (!a[MAT_W-1] && !b[MAT_W-1] && raw[MAT_W-1]) begin
         res.ovf = 1'b1;
         res.sum = {1'b0, {(MAT_W-1){1'b1}}};
      end else if (a[MAT_W-1] && b[MAT_W-1] && !raw[MAT_W-1]) begin
         res.ovf = 1'b1;
         res.sum = {1'b1, {(MAT_W-1){1'b0}}};
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/vtpd_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Divides two 64-bit magnitudes into a signed COORD_BITS quotient with
// FRAC_BITS fraction bits, truncating toward zero, one quotient bit a stage.
// It is fully pipelined with no stall, and a new word may enter every cycle.
// ----------------------------------------------------------------------------
module vtpd_div #(
   parameter int FRAC_BITS  = vtpd_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = vtpd_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic [63:0]            num_mag,
   input  logic [63:0]            den_mag,
   input  logic                   neg,
   output vtpd_pkg::div_res_type  res
);
   import vtpd_pkg::*;

   localparam int    SW      = MAT_W + COORD_BITS;
   localparam int    NW      = MAT_W + FRAC_BITS;
   localparam longint LIM_INT = (longint'(1) << (COORD_BITS - 1)) >> FRAC_BITS;
   localparam logic [SW-1:0] LMUL = SW'(LIM_INT + 1);

   typedef struct packed {
      logic [MAT_W-1:0]      rem;
      logic [MAT_W-1:0]      den;
      logic [COORD_BITS-1:0] nlow;
      logic [COORD_BITS-1:0] quo;
      logic                  neg;
      logic                  sat;
   } dstage_type;

   dstage_type  st_ff [0:COORD_BITS];
   dstage_type  st0_in;
   div_res_type res_ff;
   div_res_type res_in;

   // First stage: integer-part overflow check and initial remainder.
   always_comb begin
      logic [NW-1:0] num_sh;
      num_sh      = {num_mag, {FRAC_BITS{1'b0}}};
      st0_in.rem  = MAT_W'(num_sh >> COORD_BITS);
      st0_in.den  = den_mag;
      st0_in.nlow = num_sh[COORD_BITS-1:0];
      st0_in.quo  = '0;
      st0_in.neg  = neg;
      st0_in.sat  = (SW'(num_mag) >= (SW'(den_mag) * LMUL));
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= st0_in;
   end

   // One restoring step per stage.
   for (genvar k = 0; k < COORD_BITS; k++) begin : g_step
      dstage_type     step_in;
      logic [MAT_W:0] trial;
      logic [MAT_W:0] diff;

      always_comb begin
         trial   = {st_ff[k].rem, st_ff[k].nlow[COORD_BITS-1-k]};
         diff    = trial - {1'b0, st_ff[k].den};
         step_in = st_ff[k];
         if (!diff[MAT_W]) begin
            step_in.rem = diff[MAT_W-1:0];
         end else begin
            step_in.rem = trial[MAT_W-1:0];
         end
         step_in.quo = {st_ff[k].quo[COORD_BITS-2:0], ~diff[MAT_W]};
      end

      always_ff @(posedge clock) begin
         st_ff[k+1] <= step_in;
      end
   end

   // Final stage: clamp to the signed range and apply the sign.
   always_comb begin
      dstage_type            fin;
      logic [COORD_BITS-1:0] q;
      logic [COORD_BITS-1:0] lim;
      logic signed [COORD_BITS-1:0] val;
      fin = st_ff[COORD_BITS];
      q   = fin.quo;
      lim = {1'b1, {(COORD_BITS-1){1'b0}}};
      res_in.sat = fin.sat;
      if (fin.sat) begin
         val = fin.neg ? lim : ~lim;
      end else if (!fin.neg) begin
         if (q[COORD_BITS-1]) begin
            res_in.sat = 1'b1;
            val        = ~lim;
         end else begin
            val = q;
         end
      end else begin
         if (q > lim) begin
            res_in.sat = 1'b1;
            val        = lim;
         end else begin
            val = -q;
         end
      end
      res_in.val = COORD_W'(val);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

@@ hw/rtl/vertex_transform_perspective_divide.sv @@
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide
// Multiplies (x, y, z, 1) by a 4x4 fixed-point matrix and divides by w.
// ----------------------------------------------------------------------------
// Usage: write the eight matrix registers through csr_we, csr_index and
// csr_wdata while no vertex is in flight; reset loads the identity matrix.
// A vertex word is taken on each clock edge with start high and busy low.
// busy is always low: the pipeline takes one vertex every cycle.
// Each result word appears on the rsp_ ports for one cycle with rsp_valid
// high, once its vertex has passed one multiply stage, three sum stages and
// a magnitude stage, then the divider, which produces one quotient bit a
// stage, and last the output register that holds the result word.
// Results come out in input order. The receiver cannot stall, so nothing
// ever waits inside. Reset empties the pipeline; words in flight are lost.
// Status is zero for a good result, one when w was zero (coordinates
// zero) and two when a sum or a quotient saturated.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide #(
   parameter int FRAC_BITS  = vtpd_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = vtpd_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [vtpd_pkg::COORD_W-1:0] req_vertex_x,
   input  logic signed [vtpd_pkg::COORD_W-1:0] req_vertex_y,
   input  logic signed [vtpd_pkg::COORD_W-1:0] req_vertex_z,
   output logic                              rsp_valid,
   output logic signed [vtpd_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [vtpd_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [vtpd_pkg::COORD_W-1:0] rsp_out_z,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_we,
   input  logic [vtpd_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [vtpd_pkg::MAT_W-1:0]        csr_wdata
);
   import vtpd_pkg::*;

   localparam int DIV_LAT = COORD_BITS + 2;
   localparam int LATENCY = DIV_LAT + 6;
   localparam logic [MAT_W-1:0] ONE_LO = MAT_W'(longint'(1) << FRAC_BITS);
   localparam logic [MAT_W-1:0] ONE_HI = ONE_LO << 32;

   logic [MAT_W-1:0] mat_ff [NUM_REGS];

   // Matrix registers, identity after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0] <= ONE_LO;
         mat_ff[1] <= '0;
         mat_ff[2] <= ONE_HI;
         mat_ff[3] <= '0;
         mat_ff[4] <= '0;
         mat_ff[5] <= ONE_LO;
         mat_ff[6] <= '0;
         mat_ff[7] <= ONE_HI;
      end else if (csr_we) begin
         mat_ff[csr_index] <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // Stage 1: the twelve products and the w column shifts.
   logic signed [COORD_W-1:0] ent [4][4];
   logic signed [COORD_W-1:0] vin [3];
   logic signed [MAT_W-1:0]   prod_in [4][4];
   logic signed [MAT_W-1:0]   prod_ff [4][4];
   logic                      vld1_ff;

   always_comb begin
      logic signed [COORD_BITS-1:0] tx, ty, tz;
      tx     = req_vertex_x[COORD_BITS-1:0];
      ty     = req_vertex_y[COORD_BITS-1:0];
      tz     = req_vertex_z[COORD_BITS-1:0];
      vin[0] = COORD_W'(tx);
      vin[1] = COORD_W'(ty);
      vin[2] = COORD_W'(tz);
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            ent[r][c] = mat_ff[r*2 + c/2][(c%2)*32 +: 32];
         end
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = ent[r][c] * vin[c];
         end
         prod_in[r][3] = MAT_W'(ent[r][3]) <<< FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Stages 2 to 4: saturating row sums, one term a stage.
   logic [MAT_W-1:0] acc2_ff [4], p2a_ff [4], p3a_ff [4];
   logic [MAT_W-1:0] acc3_ff [4], p3b_ff [4];
   logic [MAT_W-1:0] h_ff [4];
   logic             sat2_ff, sat3_ff, sat4_ff;
   logic             vld2_ff, vld3_ff, vld4_ff;

   always_ff @(posedge clock) begin
      logic s2, s3, s4;
      sat_sum_type t;
      s2 = 1'b0;
      s3 = sat2_ff;
      s4 = sat3_ff;
      for (int r = 0; r < 4; r++) begin
         t = sat_add(prod_ff[r][0], prod_ff[r][1]);
         acc2_ff[r] <= t.sum;
         s2 = s2 | t.ovf;
         p2a_ff[r] <= prod_ff[r][2];
         p3a_ff[r] <= prod_ff[r][3];
         t = sat_add(acc2_ff[r], p2a_ff[r]);
         acc3_ff[r] <= t.sum;
         s3 = s3 | t.ovf;
         p3b_ff[r] <= p3a_ff[r];
         t = sat_add(acc3_ff[r], p3b_ff[r]);
         h_ff[r] <= t.sum;
         s4 = s4 | t.ovf;
      end
      sat2_ff <= s2;
      sat3_ff <= s3;
      sat4_ff <= s4;
   end

   // Stage 5: magnitudes, quotient signs and the w zero check.
   logic [MAT_W-1:0] mag_ff [4];
   logic             neg_ff [3];
   logic             wz5_ff, sat5_ff, vld5_ff;

   always_ff @(posedge clock) begin
      for (int r = 0; r < 4; r++) begin
         mag_ff[r] <= h_ff[r][MAT_W-1] ? (MAT_W'(0) - h_ff[r]) : h_ff[r];
      end
      for (int r = 0; r < 3; r++) begin
         neg_ff[r] <= h_ff[r][MAT_W-1] ^ h_ff[3][MAT_W-1];
      end
      wz5_ff  <= (h_ff[3] == '0);
      sat5_ff <= sat4_ff;
   end

   // Three divider lanes.
   div_res_type dres [3];

   for (genvar i = 0; i < 3; i++) begin : g_div
      vtpd_div #(
         .FRAC_BITS  (FRAC_BITS),
         .COORD_BITS (COORD_BITS)
      ) u_div (
         .clock   (clock),
         .num_mag (mag_ff[i]),
         .den_mag (mag_ff[3]),
         .neg     (neg_ff[i]),
         .res     (dres[i])
      );
   end

   // Flags ride alongside the dividers.
   logic wz_dly_ff  [DIV_LAT];
   logic sat_dly_ff [DIV_LAT];
   logic vld_dly_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      wz_dly_ff[0]  <= wz5_ff;
      sat_dly_ff[0] <= sat5_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         wz_dly_ff[k]  <= wz_dly_ff[k-1];
         sat_dly_ff[k] <= sat_dly_ff[k-1];
      end
   end

   // Valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            vld_dly_ff[k] <= 1'b0;
         end
      end else begin
         vld1_ff <= start && !busy;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld_dly_ff[0] <= vld5_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            vld_dly_ff[k] <= vld_dly_ff[k-1];
         end
      end
   end

   // Output word register.
   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   status_type                status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_dly_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (wz_dly_ff[DIV_LAT-1]) begin
         out_x_ff  <= '0;
         out_y_ff  <= '0;
         out_z_ff  <= '0;
         status_ff <= STATUS_WZERO;
      end else begin
         out_x_ff <= dres[0].val;
         out_y_ff <= dres[1].val;
         out_z_ff <= dres[2].val;
         if (sat_dly_ff[DIV_LAT-1] || dres[0].sat || dres[1].sat || dres[2].sat) begin
            status_ff <= STATUS_SAT;
         end else begin
            status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = out_x_ff;
   assign rsp_out_y  = out_y_ff;
   assign rsp_out_z  = out_z_ff;
   assign rsp_status = status_ff;

`ifndef SYNTHESIS
   // Every accepted vertex gives a word after the fixed latency.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LATENCY) rsp_valid)
      else $error("result word missing after latency");

   // No word appears without a vertex accepted before it.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result word without a vertex");

   // A zero w gives zero coordinates.
   a_wzero_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_WZERO) |->
         (rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0))
      else $error("w zero word with nonzero coordinates");
`endif

endmodule

@@ verif/tb_vertex_transform_perspective_divide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide: testbench
// Streams vertex words through the block under a series of matrices and
// checks every result word, field by field, against a behavioural model of
// the homogeneous multiply, the saturating sums and the truncating divide.
// ----------------------------------------------------------------------------
module tb_vertex_transform_perspective_divide;
   import vtpd_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [1:0]                status;
   } vertex_word_type;

   // Scoreboard: keeps a copy of the matrix and the queue of projected vertices.
   class projection_board;
      logic [MAT_W-1:0] matrix [NUM_REGS];
      vertex_word_type  pending [$];
      int               errors;

      function void load_identity();
         matrix[0] = 64'h0000_0000_0001_0000;
         matrix[1] = 64'd0;
         matrix[2] = 64'h0001_0000_0000_0000;
         matrix[3] = 64'd0;
         matrix[4] = 64'd0;
         matrix[5] = 64'h0000_0000_0001_0000;
         matrix[6] = 64'd0;
         matrix[7] = 64'h0001_0000_0000_0000;
         errors    = 0;
      endfunction

      function void write_reg(int idx, logic [MAT_W-1:0] val);
         matrix[idx] = val;
      endfunction

      // Signed 64-bit add clamped to the longint range.
      function longint add_clamped(longint a, longint b, inout bit sat);
         longint r;
         r = a + b;
         if (a >= 0 && b >= 0 && r < 0) begin
            sat = 1'b1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
         end
         if (a < 0 && b < 0 && r >= 0) begin
            sat = 1'b1;
            return 64'sh8000_0000_0000_0000;
         end
         return r;
      endfunction

      // Truncating divide of two values with 32 fraction bits, giving Q16.16.
      function logic [31:0] quotient(longint num, longint den, inout bit sat);
         longint unsigned mn, md, qi, rem, q, lim;
         bit neg;
         mn  = (num < 0) ? 64'd0 - num : num;
         md  = (den < 0) ? 64'd0 - den : den;
         neg = (num < 0) != (den < 0);
         lim = 64'd1 << 31;
         qi  = mn / md;
         rem = mn % md;
         if (qi > (lim >> 16)) begin
            sat = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         q = qi << 16;
         for (int i = 15; i >= 0; i--) begin
            rem = rem << 1;
            if (rem >= md) begin
               rem = rem - md;
               q   = q | (64'd1 << i);
            end
         end
         if (neg) begin
            if (q > lim) begin
               sat = 1'b1;
               q   = lim;
            end
            return 32'(64'd0 - q);
         end
         if (q > lim - 1) begin
            sat = 1'b1;
            q   = lim - 1;
         end
         return q[31:0];
      endfunction

      // Notes an accepted vertex and queues its projected result.
      function void note_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
         longint          v [4];
         longint          h [4];
         longint          e;
         bit              sat;
         vertex_word_type w;
         v[0] = longint'($signed(vx));
         v[1] = longint'($signed(vy));
         v[2] = longint'($signed(vz));
         v[3] = 64'sd65536;
         sat  = 1'b0;
         for (int r = 0; r < 4; r++) begin
            h[r] = 0;
            for (int c = 0; c < 4; c++) begin
               e    = longint'($signed(matrix[r*2 + c/2][32*(c%2) +: 32]));
               h[r] = add_clamped(h[r], e * v[c], sat);
            end
         end
         if (h[3] == 0) begin
            w.x = 0;
            w.y = 0;
            w.z = 0;
            w.status = STATUS_WZERO;
         end else begin
            w.x = quotient(h[0], h[3], sat);
            w.y = quotient(h[1], h[3], sat);
            w.z = quotient(h[2], h[3], sat);
            w.status = sat ? STATUS_SAT : STATUS_OK;
         end
         pending.push_back(w);
      endfunction

      // Compares one result word with the oldest expectation.
      function void check_word(vertex_word_type got);
         vertex_word_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word x=%h y=%h z=%h status=%0d",
                     $time, got.x, got.y, got.z, got.status);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x) begin
            $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
            errors++;
         end
         if (got.y !== want.y) begin
            $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
            errors++;
         end
         if (got.z !== want.z) begin
            $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     got.status);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [COORD_W-1:0] req_vertex_x = '0;
   logic signed [COORD_W-1:0] req_vertex_y = '0;
   logic signed [COORD_W-1:0] req_vertex_z = '0;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic signed [COORD_W-1:0] rsp_out_z;
   logic [1:0]                rsp_status;
   logic                      csr_we = 1'b0;
   logic [REG_IDX_W-1:0]      csr_index = '0;
   logic [MAT_W-1:0]          csr_wdata = '0;

   projection_board board;
   bit              idle_on = 1'b1;
   int              quiet_cycles = 0;

   localparam int LATENCY    = 40;
   localparam int QUIET_LIMIT = 4000;

   vertex_transform_perspective_divide u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z), .rsp_valid(rsp_valid),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_status(rsp_status), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Monitor: records accepted vertices and checks result words at each edge.
   always @(posedge clock) begin
      vertex_word_type got;
      if (!reset) begin
         if (start && !busy) begin
            board.note_vertex(req_vertex_x, req_vertex_y, req_vertex_z);
         end
         if (rsp_valid) begin
            got.x      = rsp_out_x;
            got.y      = rsp_out_y;
            got.z      = rsp_out_z;
            got.status = rsp_status;
            board.check_word(got);
         end
         if ((start && !busy) || rsp_valid || csr_we) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Drives one vertex word, at times after a random idle gap, and waits until it is taken.
   task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_vertex_z <= vz;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
   endtask

   // Lets the pipeline drain completely before the matrix is changed.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Writes all eight matrix registers; the pipeline must be empty.
   task automatic load_matrix(logic [MAT_W-1:0] m [NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[REG_IDX_W-1:0];
         csr_wdata <= m[i];
         @(posedge clock);
         board.write_reg(i, m[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_entry();
      case ($urandom_range(0, 6))
         0: return 32'h0;
         1: return 32'h0001_0000;
         2: return 32'hFFFF_0000;
         3: return $urandom();
         4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      endcase
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2, 3: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h7FFFFF)) - 32'sh3FFFFF);
      endcase
   endfunction

   initial begin
      logic [MAT_W-1:0] m [NUM_REGS];
      logic [31:0]      ext [4];
      board = new();
      board.load_identity();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity matrix: extremes of each coordinate pass through unchanged.
      ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      for (int i = 0; i < 4; i++) send_vertex(ext[i], ext[3-i], ext[(i+1)%4]);
      send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      drain();

      // Zero bottom row: w is zero for every vertex.
      m = '{64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000, 64'h1_0000, 64'h0,
            64'h0, 64'h1_0000, 64'h0, 64'h0};
      load_matrix(m);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      send_vertex(32'h0, 32'h0, 32'h0);
      drain();

      // Extreme entries in the first three rows: the sums overflow and clamp.
      m = '{64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
            64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
            64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF,
            64'h0000_0000_0000_0000, 64'h0000_0001_0000_0000};
      load_matrix(m);
      for (int i = 0; i < 4; i++) send_vertex(ext[i], ext[(i+2)%4], ext[(i+1)%4]);
      drain();

      // Perspective row: w = -z, so z of zero gives w zero and small z overflows.
      m = '{64'h1_0000, 64'h0, 64'h1_0000_0000_0000, 64'h0,
            64'h0, 64'h1_0000, 64'h0, 64'hFFFF_0000};
      load_matrix(m);
      send_vertex(32'h0010_0000, 32'hFFF0_0000, 32'hFFFF_0000);
      send_vertex(32'h0010_0000, 32'h0020_0000, 32'h0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h0001_8000, 32'h0003_0000, 32'h0002_0000);
      drain();

      // Random part: a fresh matrix per phase, some phases of projective form.
      for (int phase = 0; phase < 12; phase++) begin
         for (int i = 0; i < NUM_REGS; i++) m[i] = {pick_entry(), pick_entry()};
         if (phase % 3 == 0) begin
            m[6] = 64'h0;
            m[7] = {32'h0, $urandom_range(0, 1) ? 32'hFFFF_0000 : pick_entry()};
         end
         if (phase == 11) idle_on = 1'b0;
         load_matrix(m);
         for (int k = 0; k < 75; k++) begin
            send_vertex(pick_coord(), pick_coord(), pick_coord());
         end
         drain();
      end

      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
